>>> sv/psa_pkg.sv
// Shared constants for the pixel saturation adjust pipeline.
package psa_pkg;

  localparam int CHANNEL_BITS_DEF = 8;

  // Q0.16 luma weights, summing to 1.0
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  localparam int FACTOR_BITS = 10;
  localparam int TARGET_BITS = 9;
  localparam int IDX_BITS    = 2;

  // Register indexes on the configuration port
  localparam logic [IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_SCALE  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_TARGET = 2'd2;

  localparam logic [FACTOR_BITS-1:0] SCALE_RESET  = 10'd256;
  localparam logic [TARGET_BITS-1:0] TARGET_RESET = 9'd256;

endpackage

>>> sv/psa_sqrt_stage.sv
// One result bit of the pipelined integer square root, with side payload.
module psa_sqrt_stage #(
  parameter int SW    = 32,
  parameter int PW    = 16,
  parameter int BIT   = 0,
  parameter int SIDEW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_i,
  input  logic [SW-1:0]    x_i,
  input  logic [PW-1:0]    r_i,
  input  logic [SIDEW-1:0] side_i,
  output logic             v_r,
  output logic [SW-1:0]    x_r,
  output logic [PW-1:0]    r_r,
  output logic [SIDEW-1:0] side_r
);

  logic [SW:0]   trial;
  logic          take;
  logic [SW-1:0] x_nxt;
  logic [PW-1:0] r_nxt;

  // trial = 2*r*2^BIT + 4^BIT; keep the bit when it fits in the remainder
  always_comb begin
    trial = ((SW+1)'(r_i) << (BIT + 1)) + ((SW+1)'(1) << (2 * BIT));
    take  = ({1'b0, x_i} >= trial);
    x_nxt = take ? SW'({1'b0, x_i} - trial) : x_i;
    r_nxt = take ? (r_i | (PW'(1) << BIT)) : r_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      r_r    <= r_nxt;
      side_r <= side_i;
    end
  end

endmodule

>>> sv/psa_div_stage.sv
// One quotient bit of the restoring divider for all three channels.
module psa_div_stage #(
  parameter int N     = 8,
  parameter int BIT   = 0,
  parameter int SIDEW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_i,
  input  logic [N-1:0]           d_i,
  input  logic [2:0][2*N-1:0]    rem_i,
  input  logic [2:0][N-1:0]      q_i,
  input  logic [SIDEW-1:0]       side_i,
  output logic                   v_r,
  output logic [N-1:0]           d_r,
  output logic [2:0][2*N-1:0]    rem_r,
  output logic [2:0][N-1:0]      q_r,
  output logic [SIDEW-1:0]       side_r
);

  logic [2*N-1:0]          dsh;
  logic [2:0][2*N-1:0]     rem_nxt;
  logic [2:0][N-1:0]       q_nxt;

  // subtract the shifted divisor where it fits
  always_comb begin
    dsh = (2*N)'(d_i) << BIT;
    for (int i = 0; i < 3; i++) begin
      if (rem_i[i] >= dsh) begin
        rem_nxt[i] = rem_i[i] - dsh;
        q_nxt[i]   = q_i[i] | (N'(1) << BIT);
      end else begin
        rem_nxt[i] = rem_i[i];
        q_nxt[i]   = q_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_i;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

endmodule

>>> sv/pixel_saturation_adjust.sv
// Pixel saturation adjust: brightness, square root, blend and divide pipeline.
// Pipeline: square, weighted-square and brightness-sum registers, CHANNEL_BITS+8
//   square-root stages, 5 blend stages and CHANNEL_BITS divider stages, one bit per stage.
// Throughput: one pixel per cycle; the whole pipeline holds only while a result
//   waits with out_tready low.
// Reset (rst_n, synchronous): pipeline empties, mode 0, scale 1.0, target 1.0.
module pixel_saturation_adjust #(
  parameter int CHANNEL_BITS = psa_pkg::CHANNEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // tdata: red_in, green_in, blue_in (low bits up), zero padded
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]   in_tdata,
  // tdata: red_out, green_out, blue_out, left_unchanged (low bits up), zero padded
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((3*CHANNEL_BITS+8)/8)*8-1:0]   out_tdata,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psa_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [psa_pkg::FACTOR_BITS-1:0]       cfg_data
);

  localparam int N     = CHANNEL_BITS;
  localparam int PW    = N + 8;
  localparam int SW    = 2 * N + 16;
  localparam int NW    = 2 * N + 21;
  localparam int MW    = NW - 16;
  localparam int DW    = N + 10;
  localparam int BW    = N + 21;
  localparam int TOW   = ((3*N+8)/8)*8;
  localparam int SSIDE = 5 * N;
  localparam int DSIDE = 3 * N + 7;

  logic en;

  // configuration registers
  logic                            mode_r;
  logic [psa_pkg::FACTOR_BITS-1:0] scale_r;
  logic [psa_pkg::TARGET_BITS-1:0] target_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      scale_r  <= psa_pkg::SCALE_RESET;
      target_r <= psa_pkg::TARGET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        psa_pkg::REG_MODE:   mode_r   <= cfg_data[0];
        psa_pkg::REG_SCALE:  scale_r  <= cfg_data;
        psa_pkg::REG_TARGET: target_r <= cfg_data[psa_pkg::TARGET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the output slot is free or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: squares, max and min
  logic                 v1_r;
  logic [2:0][N-1:0]    c1_r;
  logic [2:0][2*N-1:0]  sq1_r;
  logic [N-1:0]         mx1_r, mn1_r;
  logic [2:0][N-1:0]    cin;
  logic [N-1:0]         mx_nxt, mn_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cin[i] = in_tdata[i*N +: N];
    end
    mx_nxt = cin[0];
    mn_nxt = cin[0];
    for (int i = 1; i < 3; i++) begin
      if (cin[i] > mx_nxt) mx_nxt = cin[i];
      if (cin[i] < mn_nxt) mn_nxt = cin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= cin;
      mx1_r <= mx_nxt;
      mn1_r <= mn_nxt;
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= (2*N)'(cin[i] * cin[i]);
      end
    end
  end

  // stage 2: weighted squares
  logic                 v2_r;
  logic [2:0][N-1:0]    c2_r;
  logic [N-1:0]         mx2_r, mn2_r;
  logic [2:0][SW-1:0]   wp2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r     <= c1_r;
      mx2_r    <= mx1_r;
      mn2_r    <= mn1_r;
      wp2_r[0] <= SW'(psa_pkg::W_RED * sq1_r[0]);
      wp2_r[1] <= SW'(psa_pkg::W_GREEN * sq1_r[1]);
      wp2_r[2] <= SW'(psa_pkg::W_BLUE * sq1_r[2]);
    end
  end

  // stage 3: brightness sum, then square root
  logic                 sv_r   [PW+1];
  logic [SW-1:0]        sx_r   [PW+1];
  logic [PW-1:0]        sr_r   [PW+1];
  logic [SSIDE-1:0]     sside_r[PW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0]    <= wp2_r[0] + wp2_r[1] + wp2_r[2];
      sr_r[0]    <= '0;
      sside_r[0] <= {mn2_r, mx2_r, c2_r};
    end
  end

  for (genvar k = 0; k < PW; k++) begin : g_sqrt
    psa_sqrt_stage #(
      .SW(SW), .PW(PW), .BIT(PW - 1 - k), .SIDEW(SSIDE)
    ) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(sv_r[k]), .x_i(sx_r[k]), .r_i(sr_r[k]), .side_i(sside_r[k]),
      .v_r(sv_r[k+1]), .x_r(sx_r[k+1]), .r_r(sr_r[k+1]), .side_r(sside_r[k+1])
    );
  end

  // stage A: offsets from brightness and mode-dependent operands
  logic [2:0][N-1:0]        cs;
  logic [N-1:0]             mxs, mns;
  logic [PW-1:0]            pbr;
  logic                     gray_nxt;
  logic [N-1:0]             dsel;

  assign cs  = sside_r[PW][3*N-1:0];
  assign mxs = sside_r[PW][4*N-1:3*N];
  assign mns = sside_r[PW][5*N-1:4*N];
  assign pbr = sr_r[PW];

  always_comb begin
    gray_nxt = mode_r && (mxs == mns);
    dsel     = (mode_r && !gray_nxt) ? (mxs - mns) : N'(1);
  end

  logic                          va_r;
  logic [2:0][N-1:0]             ca_r;
  logic                          graya_r;
  logic signed [2:0][DW-1:0]     diffa_r;
  logic [psa_pkg::FACTOR_BITS-1:0] mula_r;
  logic [N-1:0]                  coefa_r;
  logic [N-1:0]                  da_r;
  logic [PW+N-1:0]               basea_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= sv_r[PW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r    <= cs;
      graya_r <= gray_nxt;
      for (int i = 0; i < 3; i++) begin
        diffa_r[i] <= DW'({cs[i], 8'h00}) - DW'(pbr);
      end
      mula_r  <= mode_r ? (psa_pkg::FACTOR_BITS)'(target_r) : scale_r;
      coefa_r <= mode_r ? mxs : N'(1);
      da_r    <= dsel;
      basea_r <= (PW+N)'(pbr * dsel);
    end
  end

  // stage B: offset times factor or target
  logic                      vb_r;
  logic [2:0][N-1:0]         cb_r;
  logic [N-1:0]              coefb_r, db_r;
  logic                      grayb_r;
  logic signed [2:0][BW-1:0] prodb_r;
  logic [PW+N-1:0]           baseb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb_r    <= ca_r;
      grayb_r <= graya_r;
      coefb_r <= coefa_r;
      db_r    <= da_r;
      baseb_r <= basea_r;
      for (int i = 0; i < 3; i++) begin
        prodb_r[i] <= BW'($signed(diffa_r[i]) * $signed({1'b0, mula_r}));
      end
    end
  end

  // stage C: times max in set mode
  logic                      vc_r;
  logic [2:0][N-1:0]         cc_r;
  logic [N-1:0]              dc_r;
  logic                      grayc_r;
  logic signed [2:0][NW-1:0] prodc_r;
  logic [PW+N-1:0]           basec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r    <= cb_r;
      grayc_r <= grayb_r;
      dc_r    <= db_r;
      basec_r <= baseb_r;
      for (int i = 0; i < 3; i++) begin
        prodc_r[i] <= NW'($signed(prodb_r[i]) * $signed({1'b0, coefb_r}));
      end
    end
  end

  // stage D: numerator plus half divisor, dropped by 2^16
  logic [NW-1:0]             bext, rnd;
  logic signed [2:0][NW-1:0] numd;

  always_comb begin
    bext = NW'({basec_r, 8'h00});
    rnd  = NW'({dc_r, 15'h0000});
    for (int i = 0; i < 3; i++) begin
      numd[i] = $signed(bext) + prodc_r[i] + $signed(rnd);
    end
  end

  logic                 vd_r;
  logic [2:0][N-1:0]    cd_r;
  logic [N-1:0]         dd_r;
  logic                 grayd_r;
  logic [2:0][MW-1:0]   md_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r    <= cc_r;
      grayd_r <= grayc_r;
      dd_r    <= dc_r;
      for (int i = 0; i < 3; i++) begin
        md_r[i] <= numd[i][NW-1:16];
      end
    end
  end

  // stage E: negative and overflow checks, divider setup
  logic                 dv_r   [N+1];
  logic [N-1:0]         dd_arr [N+1];
  logic [2:0][2*N-1:0]  drem_r [N+1];
  logic [2:0][N-1:0]    dq_r   [N+1];
  logic [DSIDE-1:0]     dside_r[N+1];
  logic [2:0]           neg_e, sat_e;
  logic [MW-2:0]        lim_e;

  always_comb begin
    lim_e = (MW-1)'({dd_r, {N{1'b0}}});
    for (int i = 0; i < 3; i++) begin
      neg_e[i] = md_r[i][MW-1];
      sat_e[i] = !neg_e[i] && (md_r[i][MW-2:0] >= lim_e);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_arr[0]  <= dd_r;
      dq_r[0]    <= '0;
      dside_r[0] <= {sat_e, neg_e, grayd_r, cd_r};
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= md_r[i][2*N-1:0];
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_div
    psa_div_stage #(
      .N(N), .BIT(N - 1 - k), .SIDEW(DSIDE)
    ) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(dv_r[k]), .d_i(dd_arr[k]), .rem_i(drem_r[k]), .q_i(dq_r[k]),
      .side_i(dside_r[k]),
      .v_r(dv_r[k+1]), .d_r(dd_arr[k+1]), .rem_r(drem_r[k+1]), .q_r(dq_r[k+1]),
      .side_r(dside_r[k+1])
    );
  end

  // output selection: gray bypass, clamp at zero and at full scale
  logic [2:0][N-1:0] co;
  logic              grayo;
  logic [2:0]        nego, sato;
  logic [2:0][N-1:0] res;

  assign co    = dside_r[N][3*N-1:0];
  assign grayo = dside_r[N][3*N];
  assign nego  = dside_r[N][3*N+3:3*N+1];
  assign sato  = dside_r[N][3*N+6:3*N+4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (grayo) begin
        res[i] = co[i];
      end else if (nego[i]) begin
        res[i] = '0;
      end else if (sato[i]) begin
        res[i] = '1;
      end else begin
        res[i] = dq_r[N][i];
      end
    end
  end

  assign out_tvalid = dv_r[N];
  assign out_tdata  = TOW'({grayo, res});

endmodule

>>> sim/psa_checker.sv
// Checker for pixel_saturation_adjust: tracks registers, predicts pixels, compares results.
`timescale 1ns / 1ps

module psa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [psa_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [psa_pkg::FACTOR_BITS-1:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int CB = psa_pkg::CHANNEL_BITS_DEF;
  localparam longint CH_MAX = (64'd1 << CB) - 1;

  // result fields, red in the lowest bits
  typedef struct packed {
    logic          left_unchanged;
    logic [CB-1:0] blue;
    logic [CB-1:0] green;
    logic [CB-1:0] red;
  } pixel_t;

  logic                            mode_q;
  logic [psa_pkg::FACTOR_BITS-1:0] scale_q;
  logic [psa_pkg::TARGET_BITS-1:0] target_q;
  pixel_t                          expected_pixels[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // round half up, clamp to channel range
  function automatic logic [CB-1:0] round_sat(longint num, longint den);
    longint n2;
    longint q;
    n2 = 2 * num + den;
    if (n2 < 0) return '0;
    q = n2 / (2 * den);
    return (q > CH_MAX) ? CH_MAX[CB-1:0] : q[CB-1:0];
  endfunction

  function automatic pixel_t adjust_pixel(logic [23:0] px);
    longint ch[3];
    longint mx, mn, p, diff, num, den, d;
    longint unsigned s;
    pixel_t res;
    logic [CB-1:0] outc[3];
    ch[0] = longint'(px[7:0]);
    ch[1] = longint'(px[15:8]);
    ch[2] = longint'(px[23:16]);
    mx = ch[0];
    mn = ch[0];
    for (int i = 1; i < 3; i++) begin
      if (ch[i] > mx) mx = ch[i];
      if (ch[i] < mn) mn = ch[i];
    end
    s = psa_pkg::W_RED * ch[0] * ch[0] + psa_pkg::W_GREEN * ch[1] * ch[1]
        + psa_pkg::W_BLUE * ch[2] * ch[2];
    p = root_floor(s);
    // gray pixel in set mode passes through
    if (mode_q && mx == mn) begin
      res = {1'b1, px[23:16], px[15:8], px[7:0]};
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      diff = (ch[i] << 8) - p;
      if (!mode_q) begin
        num = (p << 8) + diff * longint'(scale_q);
        den = 65536;
      end else begin
        d   = mx - mn;
        num = (p << 8) * d + diff * longint'(target_q) * mx;
        den = 65536 * d;
      end
      outc[i] = round_sat(num, den);
    end
    res = {1'b0, outc[2], outc[1], outc[0]};
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, exp, $realtime);
    fail_count++;
  endtask

  assign pending = expected_pixels.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    pixel_t got;
    pixel_t exp;
    if (!rst_n) begin
      mode_q   <= 1'b0;
      scale_q  <= psa_pkg::SCALE_RESET;
      target_q <= psa_pkg::TARGET_RESET;
      expected_pixels.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psa_pkg::REG_MODE:   mode_q   <= cfg_data[0];
          psa_pkg::REG_SCALE:  scale_q  <= cfg_data;
          psa_pkg::REG_TARGET: target_q <= cfg_data[psa_pkg::TARGET_BITS-1:0];
          default: ;
        endcase
      end
      // new pixel request
      if (in_tvalid && in_tready) expected_pixels.push_back(adjust_pixel(in_tdata));
      // result request
      if (out_tvalid && out_tready) begin
        got = out_tdata[3*CB:0];
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result", int'(got), 0);
        end else begin
          exp = expected_pixels.pop_front();
          if (got.red != exp.red) report_mismatch("red_out", got.red, exp.red);
          if (got.green != exp.green) report_mismatch("green_out", got.green, exp.green);
          if (got.blue != exp.blue) report_mismatch("blue_out", got.blue, exp.blue);
          if (got.left_unchanged != exp.left_unchanged)
            report_mismatch("left_unchanged", got.left_unchanged, exp.left_unchanged);
        end
      end
    end
  end

endmodule

>>> sim/tb_pixel_saturation_adjust.sv
// Testbench top for pixel_saturation_adjust: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_pixel_saturation_adjust;

  localparam int LATENCY   = 2 * psa_pkg::CHANNEL_BITS_DEF + 16;
  localparam int STALL_MAX = 3000;
  localparam int PER_PHASE = 56;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [psa_pkg::IDX_BITS-1:0]    cfg_index;
  logic [psa_pkg::FACTOR_BITS-1:0] cfg_data;
  int          fail_count, pending;
  int          send_idle_pct, recv_stall_pct;
  int          quiet_cycles = 0;

  pixel_saturation_adjust u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  psa_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // stop on a run with no progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("FAIL pixel_saturation_adjust");
      $finish;
    end
  end

  // valid stays high across back-to-back writes; set_regs drops it
  task automatic write_reg(logic [psa_pkg::IDX_BITS-1:0] idx,
                           logic [psa_pkg::FACTOR_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // pixel request, after a random number of idle cycles
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic finish_send();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all results, then let the pipeline settle
  task automatic drain();
    finish_send();
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_regs(logic m, logic [psa_pkg::FACTOR_BITS-1:0] f,
                          logic [psa_pkg::TARGET_BITS-1:0] t);
    write_reg(psa_pkg::REG_MODE, {9'($urandom), m});
    write_reg(psa_pkg::REG_SCALE, f);
    write_reg(psa_pkg::REG_TARGET, {1'($urandom), t});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pixel();
    logic [7:0] r, g, b;
    int kind;
    kind = int'($urandom_range(7));
    r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
    if (kind == 0) begin
      g = r;
      b = r;
    end else if (kind == 1) begin
      r = {8{r[0]}}; g = {8{g[0]}}; b = {8{b[0]}};
    end else if (kind == 2) begin
      g = r + 8'($urandom_range(2));
      b = r;
    end
    send_pixel(r, g, b);
  endtask

  task automatic directed_set();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd255);
  endtask

  initial begin
    logic                            m;
    logic [psa_pkg::FACTOR_BITS-1:0] f;
    logic [psa_pkg::TARGET_BITS-1:0] t;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = psa_pkg::REG_MODE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then set mode at target 1.0
    directed_set();
    drain();
    set_regs(1'b1, 10'd256, 9'd256);
    directed_set();
    drain();

    // random phases over register settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (ph)
        0: begin m = 1'b0; f = 10'd0;    t = 9'd0;   end
        1: begin m = 1'b0; f = 10'd1023; t = 9'd511; end
        2: begin m = 1'b0; f = 10'($urandom); t = 9'($urandom); end
        3: begin m = 1'b1; f = 10'd0;    t = 9'd0;   end
        4: begin m = 1'b1; f = 10'd1023; t = 9'd511; end
        5: begin m = 1'b1; f = 10'($urandom); t = 9'd256; end
        6: begin m = 1'b1; f = 10'($urandom); t = 9'($urandom); end
        default: begin m = 1'b0; f = 10'd256; t = 9'($urandom); end
      endcase
      set_regs(m, f, t);
      for (int i = 0; i < PER_PHASE; i++) random_pixel();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS pixel_saturation_adjust");
    end else begin
      $display("FAIL pixel_saturation_adjust");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/psa_pkg.sv
sv/psa_sqrt_stage.sv
sv/psa_div_stage.sv
sv/pixel_saturation_adjust.sv
sim/psa_checker.sv
sim/tb_pixel_saturation_adjust.sv
